FILE: hw/rtl/gons_pkg.sv
package gons_pkg;

	localparam int GRID_SIZE_DEF = 64;
	localparam int FRAC_BITS_DEF = 4;
	localparam int QUEUE_DEPTH   = 2;

	localparam int POS_W     = 10;
	localparam int HEAD_W    = 16;
	localparam int CMD_W     = 2;
	localparam int REACH_W   = 5;
	localparam int FOUND_W   = 6;
	localparam int OCC_W     = 13;
	localparam int CFG_IDX_W = 2;

	localparam logic [REACH_W-1:0]   SIDE_RST = REACH_W'(2);
	localparam logic [REACH_W-1:0]   FWD_RST  = REACH_W'(4);
	localparam logic [CFG_IDX_W-1:0] REG_SIDE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_FWD  = CFG_IDX_W'(1);

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD,
		CMD_REMOVE,
		CMD_QUERY,
		CMD_SEARCH
	} cmd_t;

	// Heading rounded to the nearest quarter turn.
	typedef enum logic [1:0] {
		QUAD_POS_X,
		QUAD_POS_Y,
		QUAD_NEG_X,
		QUAD_NEG_Y
	} quad_t;

	typedef struct packed {
		cmd_t              cmd;
		logic [POS_W-1:0]  pos_x;
		logic [POS_W-1:0]  pos_y;
		quad_t             quad;
		logic              on_grid;
	} item_t;

	typedef struct packed {
		logic [REACH_W-1:0] side;
		logic [REACH_W-1:0] fwd;
	} reach_t;

endpackage

FILE: hw/rtl/gons_in_if.sv
interface gons_in_if import gons_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [POS_W-1:0]  pos_x;
	logic [POS_W-1:0]  pos_y;
	logic [HEAD_W-1:0] heading;

	modport source (output valid, command, pos_x, pos_y, heading, input ready);
	modport sink (input valid, command, pos_x, pos_y, heading, output ready);
endinterface

FILE: hw/rtl/gons_out_if.sv
interface gons_out_if import gons_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               hit;
	logic [FOUND_W-1:0] found_x;
	logic [FOUND_W-1:0] found_y;
	logic [OCC_W-1:0]   occupied_count;

	modport source (output valid, hit, found_x, found_y, occupied_count, input ready);
	modport sink (input valid, hit, found_x, found_y, occupied_count, output ready);
endinterface

FILE: hw/rtl/grid_occupancy_nearest_search.sv
// Occupancy grid with a windowed nearest-cell search.
// Commands arrive on in_ch (add, remove, query, search) and each one gives
// exactly one result transfer on out_ch, in order. The search window reach is
// set through the write port (cfg_we, cfg_index, cfg_data); the user must write
// it only while the block is idle; the block itself does not enforce this.
// A front stage classifies each command and rounds the heading to a quadrant,
// then a two-entry queue hands it to the back end, which owns the bitmap.
// Add, remove and query pass through the setup, update and done states. A
// search scans the window column by column: the back end reads one column word
// of the bitmap per cycle and pushes it through a three-stage nearest-row and
// distance pipeline, then drains it. One command is in the back end at a time.
// Reset empties the grid, zeroes the count and loads side reach 2 and forward
// reach 4; the per-column valid flags clear at once, so no sweep is needed.
// When the receiver stalls, the result waits in the output register, the back
// end holds its next result, and the queue keeps taking commands until full.
module grid_occupancy_nearest_search import gons_pkg::*; #(
	parameter int GRID_SIZE = GRID_SIZE_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [REACH_W-1:0]    cfg_data,
	gons_in_if.sink               in_ch,
	gons_out_if.source            out_ch
);

	reach_t reach_q;
	logic   push, full, empty, pop;
	item_t  push_item, pop_item;

	// Writes to an index past the register list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reach_q.side <= SIDE_RST;
			reach_q.fwd  <= FWD_RST;
		end else if (cfg_we) begin
			if (cfg_index == REG_SIDE) begin
				reach_q.side <= cfg_data;
			end
			if (cfg_index == REG_FWD) begin
				reach_q.fwd <= cfg_data;
			end
		end
	end

	gons_front #(
		.GRID_SIZE (GRID_SIZE),
		.FRAC_BITS (FRAC_BITS)
	) u_front (
		.in_ch     (in_ch),
		.push      (push),
		.push_item (push_item),
		.full      (full)
	);

	gons_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.pop_item  (pop_item),
		.empty     (empty)
	);

	gons_back #(
		.GRID_SIZE (GRID_SIZE),
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.reach   (reach_q),
		.q_empty (empty),
		.pop     (pop),
		.item    (pop_item),
		.out_ch  (out_ch)
	);

endmodule

FILE: hw/rtl/gons_front.sv
module gons_front import gons_pkg::*; #(
	parameter int GRID_SIZE = GRID_SIZE_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	gons_in_if.sink     in_ch,
	output logic        push,
	output item_t       push_item,
	input  logic        full
);

	localparam int CW = POS_W - FRAC_BITS;
	localparam logic [HEAD_W-1:0] HALF_QUAD = HEAD_W'(1) << (HEAD_W - 3);

	logic [CW-1:0]     cx;
	logic [CW-1:0]     cy;
	logic [HEAD_W-1:0] head_rnd;

	assign in_ch.ready = !full;
	assign push        = in_ch.valid && !full;

	assign cx       = in_ch.pos_x[POS_W-1:FRAC_BITS];
	assign cy       = in_ch.pos_y[POS_W-1:FRAC_BITS];
	// Adding an eighth turn before truncation rounds to the nearest quadrant, ties upward.
	assign head_rnd = in_ch.heading + HALF_QUAD;

	always_comb begin
		push_item.cmd     = cmd_t'(in_ch.command);
		push_item.pos_x   = in_ch.pos_x;
		push_item.pos_y   = in_ch.pos_y;
		push_item.quad    = quad_t'(head_rnd[HEAD_W-1 -: 2]);
		push_item.on_grid = (32'(cx) < 32'(GRID_SIZE)) && (32'(cy) < 32'(GRID_SIZE));
	end

endmodule

FILE: hw/rtl/gons_queue.sv
module gons_queue import gons_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output item_t pop_item,
	output logic  empty
);

	localparam int PW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNW = $clog2(DEPTH + 1);

	item_t          slot_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CNW-1:0] cnt_q;
	logic           do_push;
	logic           do_pop;

	assign full     = cnt_q == CNW'(DEPTH);
	assign empty    = cnt_q == '0;
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_item = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: hw/rtl/gons_back.sv
module gons_back import gons_pkg::*; #(
	parameter int GRID_SIZE = GRID_SIZE_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  reach_t      reach,
	input  logic        q_empty,
	output logic        pop,
	input  item_t       item,
	gons_out_if.source  out_ch
);

	localparam int IW   = $clog2(GRID_SIZE);
	localparam int CW   = POS_W - FRAC_BITS;
	localparam int SW   = CW + 7;
	localparam int DW   = ((POS_W > IW + FRAC_BITS) ? POS_W : IW + FRAC_BITS) + 1;
	localparam int QW   = 2 * DW;
	localparam int CNTW = 2 * IW + 1;
	localparam logic signed [SW-1:0] GRID_MAX = SW'(GRID_SIZE - 1);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SETUP  = 3'd1;
	localparam logic [2:0] ST_UPDATE = 3'd2;
	localparam logic [2:0] ST_SCAN   = 3'd3;
	localparam logic [2:0] ST_DRAIN  = 3'd4;
	localparam logic [2:0] ST_DONE   = 3'd5;

	logic [2:0]      st_q;
	item_t           item_q;
	logic [IW-1:0]   col_q, x1_q, y0_q, y1_q;
	logic [CNTW-1:0] count_q;
	logic            hit_q;
	logic [IW-1:0]   fx_q, fy_q;
	logic            found_q;
	logic [QW:0]     best_q;
	logic [IW-1:0]   bx_q, by_q;
	logic            out_valid_q;
	logic                out_hit_q;
	logic [FOUND_W-1:0]  out_fx_q, out_fy_q;
	logic [OCC_W-1:0]    out_occ_q;

	// Column-major bitmap: one word per column, one bit per row.
	logic [GRID_SIZE-1:0] mem_q [GRID_SIZE];
	logic [GRID_SIZE-1:0] col_valid_q;

	logic [SW-1:0] cx_w, cy_w;
	logic signed [SW-1:0] cxs, cys, s, f, x0, x1, y0, y1, x0c, x1c, y0c, y1c;
	logic win_empty;

	logic                 rd_en, wr_en;
	logic [IW-1:0]        rd_col;
	logic [GRID_SIZE-1:0] wr_data, onehot;
	logic                 cell_bit;

	logic                 v_s1, colv_s1;
	logic [IW-1:0]        col_s1;
	logic [GRID_SIZE-1:0] raw_s1, data_s1;

	logic [GRID_SIZE-1:0] lower, upper;
	logic                 lo_ok, up_ok;
	logic [IW-1:0]        lo_idx, up_idx;
	logic                 v_s2, lo_ok_s2, up_ok_s2;
	logic [IW-1:0]        col_s2, lo_idx_s2, up_idx_s2;

	logic signed [DW-1:0] dx, dyl, dyu;
	logic signed [QW-1:0] dxe, dyle, dyue;
	logic                 v_s3, lo_ok_s3, up_ok_s3;
	logic [IW-1:0]        col_s3, lo_idx_s3, up_idx_s3;
	logic [QW-1:0]        dx2_s3, dyl2_s3, dyu2_s3;

	logic [QW:0]          dl, du, cand_d;
	logic                 take_lo, better;
	logic [IW-1:0]        cand_row;
	logic                 out_free;

	assign cx_w = SW'(item_q.pos_x[POS_W-1:FRAC_BITS]);
	assign cy_w = SW'(item_q.pos_y[POS_W-1:FRAC_BITS]);

	// Search window, clipped to the grid.
	always_comb begin
		cxs = signed'(cx_w);
		cys = signed'(cy_w);
		s   = signed'(SW'(reach.side));
		f   = signed'(SW'(reach.fwd));
		unique case (item_q.quad)
			QUAD_POS_X: begin x0 = cxs;     x1 = cxs + f; y0 = cys - s; y1 = cys + s; end
			QUAD_POS_Y: begin x0 = cxs - s; x1 = cxs + s; y0 = cys;     y1 = cys + f; end
			QUAD_NEG_X: begin x0 = cxs - f; x1 = cxs;     y0 = cys - s; y1 = cys + s; end
			QUAD_NEG_Y: begin x0 = cxs - s; x1 = cxs + s; y0 = cys - f; y1 = cys;     end
		endcase
		x0c = (x0 < 0) ? '0 : x0;
		y0c = (y0 < 0) ? '0 : y0;
		x1c = (x1 > GRID_MAX) ? GRID_MAX : x1;
		y1c = (y1 > GRID_MAX) ? GRID_MAX : y1;
		win_empty = (x0c > x1c) || (y0c > y1c);
	end

	assign pop      = (st_q == ST_IDLE) && !q_empty;
	assign rd_en    = ((st_q == ST_SETUP) && (item_q.cmd != CMD_SEARCH)) || (st_q == ST_SCAN);
	assign rd_col   = (st_q == ST_SCAN) ? col_q : cx_w[IW-1:0];
	assign data_s1  = colv_s1 ? raw_s1 : '0;
	assign cell_bit = data_s1[cy_w[IW-1:0]];
	assign onehot   = GRID_SIZE'(1) << cy_w[IW-1:0];
	assign wr_data  = (item_q.cmd == CMD_ADD) ? (data_s1 | onehot) : (data_s1 & ~onehot);
	assign wr_en    = (st_q == ST_UPDATE) && item_q.on_grid &&
		(((item_q.cmd == CMD_ADD) && !cell_bit) || ((item_q.cmd == CMD_REMOVE) && cell_bit));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[cx_w[IW-1:0]] <= wr_data;
		end
		if (rd_en) begin
			raw_s1  <= mem_q[rd_col];
			colv_s1 <= col_valid_q[rd_col];
			col_s1  <= rd_col;
		end
	end

	// Within one column, the nearest set row at or below the position row and the
	// nearest one above it; only these two can be the column's closest cell.
	always_comb begin
		lower  = '0;
		upper  = '0;
		lo_ok  = 1'b0;
		up_ok  = 1'b0;
		lo_idx = '0;
		up_idx = '0;
		for (int r = 0; r < GRID_SIZE; r++) begin
			if ((IW'(r) >= y0_q) && (IW'(r) <= y1_q)) begin
				if (SW'(r) <= cy_w) begin
					lower[r] = data_s1[r];
				end else begin
					upper[r] = data_s1[r];
				end
			end
		end
		for (int r = 0; r < GRID_SIZE; r++) begin
			if (lower[r]) begin
				lo_ok  = 1'b1;
				lo_idx = IW'(r);
			end
		end
		for (int r = GRID_SIZE - 1; r >= 0; r--) begin
			if (upper[r]) begin
				up_ok  = 1'b1;
				up_idx = IW'(r);
			end
		end
	end

	always_comb begin
		dx   = signed'(DW'(item_q.pos_x)) - signed'(DW'(col_s2) << FRAC_BITS);
		dyl  = signed'(DW'(item_q.pos_y)) - signed'(DW'(lo_idx_s2) << FRAC_BITS);
		dyu  = signed'(DW'(item_q.pos_y)) - signed'(DW'(up_idx_s2) << FRAC_BITS);
		dxe  = QW'(dx);
		dyle = QW'(dyl);
		dyue = QW'(dyu);
	end

	// The lower candidate wins a tie with the upper one.
	always_comb begin
		dl       = (QW + 1)'(dx2_s3) + (QW + 1)'(dyl2_s3);
		du       = (QW + 1)'(dx2_s3) + (QW + 1)'(dyu2_s3);
		take_lo  = lo_ok_s3 && (!up_ok_s3 || (dl <= du));
		cand_d   = take_lo ? dl : du;
		cand_row = take_lo ? lo_idx_s3 : up_idx_s3;
		better   = v_s3 && (lo_ok_s3 || up_ok_s3) && (!found_q || (cand_d < best_q));
	end

	always_ff @(posedge clk) begin
		lo_ok_s2  <= lo_ok;
		up_ok_s2  <= up_ok;
		lo_idx_s2 <= lo_idx;
		up_idx_s2 <= up_idx;
		col_s2    <= col_s1;
		lo_ok_s3  <= lo_ok_s2;
		up_ok_s3  <= up_ok_s2;
		lo_idx_s3 <= lo_idx_s2;
		up_idx_s3 <= up_idx_s2;
		col_s3    <= col_s2;
		dx2_s3    <= unsigned'(dxe * dxe);
		dyl2_s3   <= unsigned'(dyle * dyle);
		dyu2_s3   <= unsigned'(dyue * dyue);
		if (better) begin
			best_q <= cand_d;
			bx_q   <= col_s3;
			by_q   <= cand_row;
		end
		if (pop) begin
			item_q <= item;
		end
		if (st_q == ST_SETUP) begin
			col_q <= x0c[IW-1:0];
			x1_q  <= x1c[IW-1:0];
			y0_q  <= y0c[IW-1:0];
			y1_q  <= y1c[IW-1:0];
			hit_q <= 1'b0;
			fx_q  <= '0;
			fy_q  <= '0;
		end else if (st_q == ST_SCAN) begin
			col_q <= col_q + 1'b1;
		end
		if (st_q == ST_UPDATE) begin
			hit_q <= (item_q.cmd == CMD_QUERY) && item_q.on_grid && cell_bit;
		end
		if (st_q == ST_DRAIN) begin
			hit_q <= found_q;
			fx_q  <= found_q ? bx_q : '0;
			fy_q  <= found_q ? by_q : '0;
		end
		if ((st_q == ST_DONE) && out_free) begin
			out_hit_q <= hit_q;
			out_fx_q  <= FOUND_W'(fx_q);
			out_fy_q  <= FOUND_W'(fy_q);
			out_occ_q <= OCC_W'(count_q);
		end
	end

	assign out_free = !out_valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			found_q     <= 1'b0;
			count_q     <= '0;
			col_valid_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= (st_q == ST_SCAN);
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (better) begin
				found_q <= 1'b1;
			end
			if (wr_en) begin
				col_valid_q[cx_w[IW-1:0]] <= 1'b1;
				count_q <= (item_q.cmd == CMD_ADD) ? count_q + 1'b1 : count_q - 1'b1;
			end
			if ((st_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (!q_empty) begin
						st_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					found_q <= 1'b0;
					if (item_q.cmd != CMD_SEARCH) begin
						st_q <= ST_UPDATE;
					end else if (win_empty) begin
						st_q <= ST_DONE;
					end else begin
						st_q <= ST_SCAN;
					end
				end
				ST_UPDATE: st_q <= ST_DONE;
				ST_SCAN: begin
					if (col_q == x1_q) begin
						st_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!v_s1 && !v_s2 && !v_s3) begin
						st_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.hit            = out_hit_q;
	assign out_ch.found_x        = out_fx_q;
	assign out_ch.found_y        = out_fy_q;
	assign out_ch.occupied_count = out_occ_q;

endmodule
